// ----- hw/rtl/mexp_pkg.sv -----
`timescale 1ns / 1ps

package mexp_pkg;

    // operand width, used by the payload structs
    localparam int OPERAND_WIDTH = 31;
    // bit counter for one pass over an operand
    localparam int CNT_W = $clog2(OPERAND_WIDTH);

    typedef struct packed {
        logic [OPERAND_WIDTH-1:0] base_value;
        logic [OPERAND_WIDTH-1:0] exponent;
        logic [OPERAND_WIDTH-1:0] modulus;
    } in_beat_t;

    typedef struct packed {
        logic [OPERAND_WIDTH-1:0] power_result;
        logic                     zero_modulus_error;
    } out_beat_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_MUL    = 5'b00100,
        ST_SQR    = 5'b01000,
        ST_FINISH = 5'b10000
    } mexp_state_t;

endpackage

// ----- hw/rtl/mexp_modstep.sv -----
`timescale 1ns / 1ps

// one shift-and-add step: (2*acc + addend) mod modulus, for acc < modulus
// and a sum below three times the modulus
module mexp_modstep
    import mexp_pkg::*;
(
    input  logic [OPERAND_WIDTH-1:0] acc,
    input  logic [OPERAND_WIDTH-1:0] addend,
    input  logic [OPERAND_WIDTH-1:0] modulus,
    output logic [OPERAND_WIDTH-1:0] result
);

    localparam int SW = OPERAND_WIDTH + 2;

    logic [SW-1:0] sum0;
    logic [SW-1:0] mod1;
    logic [SW-1:0] mod2;
    logic [SW-1:0] sum1;
    logic [SW-1:0] sum2;

    always_comb begin
        sum0 = {1'b0, acc, 1'b0} + {2'b00, addend};
        mod1 = {2'b00, modulus};
        mod2 = {1'b0, modulus, 1'b0};
        sum1 = sum0 - mod1;
        sum2 = sum0 - mod2;
        priority if (sum0 >= mod2) begin
            result = sum2[OPERAND_WIDTH-1:0];
        end else if (sum0 >= mod1) begin
            result = sum1[OPERAND_WIDTH-1:0];
        end else begin
            result = sum0[OPERAND_WIDTH-1:0];
        end
    end

endmodule

// ----- hw/rtl/modular_exponentiation_core.sv -----
`timescale 1ns / 1ps

// modular exponentiation core: base ** exponent mod modulus
//
// input channel s_valid/s_ready/s_data carries base, exponent and modulus;
// result channel m_valid/m_ready/m_data returns one beat per input beat
// with the power and a zero-modulus flag (result 0 when flagged)
//
// one beat at a time: s_ready is high only while the core is idle, so a new
// beat is taken only after the previous one has left the finish state
// from the accepting edge: a zero modulus goes straight to the finish state;
// otherwise one pass to reduce the base, then one pass for each multiply and
// each square (a pass covers the W = OPERAND_WIDTH bits of an operand), then
// the finish state loads the output register; each exponent bit below the top
// set bit costs a square and each set bit a multiply, so a zero exponent
// needs the reduction pass alone; all of it is done by the single modular
// shift-and-add step, used once a cycle
// the result sits in an output register; the next beat is accepted while
// it waits, and a finished result waits in the finish state until the
// receiver takes the previous one
// reset (aresetn low, synchronous) empties the core and drops m_valid
module modular_exponentiation_core
    import mexp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_WIDTH - 1);
    localparam logic [OPERAND_WIDTH-1:0] ONE = OPERAND_WIDTH'(1);

    mexp_state_t state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [OPERAND_WIDTH-1:0] mod_reg, mod_next;
    logic [OPERAND_WIDTH-1:0] base_reg, base_next;   // running base
    logic [OPERAND_WIDTH-1:0] res_reg, res_next;     // running result
    logic [OPERAND_WIDTH-1:0] exp_reg, exp_next;
    logic [OPERAND_WIDTH-1:0] work_reg, work_next;   // step accumulator
    logic [OPERAND_WIDTH-1:0] scan_reg, scan_next;   // operand scanned msb first
    logic                     err_reg, err_next;
    out_beat_t                out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    logic [OPERAND_WIDTH-1:0] addend;
    logic [OPERAND_WIDTH-1:0] step_res;
    logic [OPERAND_WIDTH-1:0] exp_shr;
    logic                     pass_end;
    logic                     out_free;

    // the shared arithmetic step
    mexp_modstep u_step (
        .acc     (work_reg),
        .addend  (addend),
        .modulus (mod_reg),
        .result  (step_res)
    );

    // base reduction shifts in base bits; multiplies and squares add the base on set bits
    always_comb begin
        if (state_reg == ST_REDUCE) begin
            addend = {{(OPERAND_WIDTH-1){1'b0}}, scan_reg[OPERAND_WIDTH-1]};
        end else begin
            addend = scan_reg[OPERAND_WIDTH-1] ? base_reg : '0;
        end
    end

    assign exp_shr  = exp_reg >> 1;
    assign pass_end = (cnt_reg == CNT_LAST);
    assign out_free = !out_valid_reg || m_ready;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mod_next       = mod_reg;
        base_next      = base_reg;
        res_next       = res_reg;
        exp_next       = exp_reg;
        work_next      = work_reg;
        scan_next      = scan_reg;
        err_next       = err_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mod_next  = s_data.modulus;
                    exp_next  = s_data.exponent;
                    scan_next = s_data.base_value;
                    work_next = '0;
                    cnt_next  = '0;
                    // result starts at one and is returned as is for a zero exponent
                    res_next  = ONE;
                    err_next  = (s_data.modulus == '0);
                    if (s_data.modulus == '0) begin
                        res_next   = '0;
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE, ST_MUL, ST_SQR: begin
                work_next = step_res;
                scan_next = scan_reg << 1;
                cnt_next  = cnt_reg + 1'b1;
                if (pass_end) begin
                    work_next = '0;
                    cnt_next  = '0;
                    unique case (state_reg)
                        ST_REDUCE: begin
                            base_next = step_res;
                            if (exp_reg == '0) begin
                                state_next = ST_FINISH;
                            end else if (exp_reg[0]) begin
                                scan_next  = res_reg;
                                state_next = ST_MUL;
                            end else begin
                                scan_next  = step_res;
                                state_next = ST_SQR;
                            end
                        end
                        ST_MUL: begin
                            res_next = step_res;
                            // no square after the top exponent bit
                            if (exp_shr == '0) begin
                                state_next = ST_FINISH;
                            end else begin
                                scan_next  = base_reg;
                                state_next = ST_SQR;
                            end
                        end
                        default: begin
                            base_next = step_res;
                            exp_next  = exp_shr;
                            if (exp_shr[0]) begin
                                scan_next  = res_reg;
                                state_next = ST_MUL;
                            end else begin
                                scan_next  = step_res;
                                state_next = ST_SQR;
                            end
                        end
                    endcase
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_next.power_result       = res_reg;
                    out_next.zero_modulus_error = err_reg;
                    out_valid_next              = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        mod_reg  <= mod_next;
        base_reg <= base_next;
        res_reg  <= res_next;
        exp_reg  <= exp_next;
        work_reg <= work_next;
        scan_reg <= scan_next;
        err_reg  <= err_next;
        out_reg  <= out_next;
    end

endmodule

// ----- sim/mexp_result_monitor.sv -----
`timescale 1ns / 1ps

module mexp_result_monitor
    import mexp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_beat_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_beat_t m_data,
    output int        fail_count,
    output int        pending
);

    out_beat_t awaited_powers[$];
    out_beat_t wanted;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // base ** exponent mod modulus, products kept at double width
    function automatic out_beat_t power_mod(in_beat_t operands);
        out_beat_t                  answer;
        logic [2*OPERAND_WIDTH-1:0] modulus_wide;
        logic [2*OPERAND_WIDTH-1:0] running_base;
        logic [2*OPERAND_WIDTH-1:0] running_power;
        logic [OPERAND_WIDTH-1:0]   exp_left;
        answer = '0;
        if (operands.modulus == '0) begin
            answer.zero_modulus_error = 1'b1;
            return answer;
        end
        modulus_wide  = {{OPERAND_WIDTH{1'b0}}, operands.modulus};
        running_base  = {{OPERAND_WIDTH{1'b0}}, operands.base_value} % modulus_wide;
        // starts at one and is only reduced on a multiply, so a zero
        // exponent gives one even for modulus one
        running_power = {{(2*OPERAND_WIDTH-1){1'b0}}, 1'b1};
        exp_left      = operands.exponent;
        while (exp_left != '0) begin
            if (exp_left[0]) begin
                running_power = ((running_power % modulus_wide) * running_base)
                                % modulus_wide;
            end
            running_base = (running_base * running_base) % modulus_wide;
            exp_left     = exp_left >> 1;
        end
        answer.power_result = running_power[OPERAND_WIDTH-1:0];
        return answer;
    endfunction

    task automatic report_mismatch(string detail);
        $display("[%0t] result monitor: %s", $time, detail);
        fail_count = fail_count + 1;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            awaited_powers.delete();
            pending <= 0;
        end else begin
            // result side first, so a stray beat never takes a fresh entry
            if (m_valid && m_ready) begin
                if (awaited_powers.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing outstanding: %h",
                                              m_data));
                end else begin
                    wanted = awaited_powers.pop_front();
                    if (m_data.power_result !== wanted.power_result)
                        report_mismatch($sformatf("power_result %h, wanted %h",
                                                  m_data.power_result,
                                                  wanted.power_result));
                    if (m_data.zero_modulus_error !== wanted.zero_modulus_error)
                        report_mismatch($sformatf("zero_modulus_error %b, wanted %b",
                                                  m_data.zero_modulus_error,
                                                  wanted.zero_modulus_error));
                end
            end
            if (s_valid && s_ready)
                awaited_powers.insert(awaited_powers.size(), power_mod(s_data));
            pending <= awaited_powers.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import mexp_pkg::*;

    localparam int RANDOM_BEATS   = 270;
    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLD_AT_RESULT = 40;
    localparam int HOLD_CYCLES    = 6000;
    localparam logic [OPERAND_WIDTH-1:0] ALL_ONES = '1;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;
    int        fail_count;
    int        pending;
    int        cycle_count = 0;

    modular_exponentiation_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    mexp_result_monitor result_monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // offer one beat after an optional random gap, hold it until taken
    task automatic offer_beat(in_beat_t beat, bit idling);
        int gap;
        gap = 0;
        while (idling && $urandom_range(99) < 16) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // result side: random stalls, one long hold-off, one stretch always ready
    initial begin
        int  rx_beats;
        int  rx_cycle;
        int  hold_left;
        bit  held;
        rx_beats  = 0;
        rx_cycle  = 0;
        hold_left = 0;
        held      = 1'b0;
        m_ready  <= 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            rx_cycle++;
            if (m_valid && m_ready) rx_beats++;
            if (!held && rx_beats >= HOLD_AT_RESULT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_cycle >= 40000 && rx_cycle < 80000) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 16);
            end
        end
    end

    initial begin
        in_beat_t beat;
        int       pick;
        int       exp_bits;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero modulus, zero exponent, modulus one, operand extremes
        offer_beat(in_beat_t'{31'd5, 31'd3, 31'd0}, 1'b1);
        offer_beat(in_beat_t'{ALL_ONES, ALL_ONES, 31'd0}, 1'b1);
        offer_beat(in_beat_t'{31'd7, 31'd0, 31'd1}, 1'b1);
        offer_beat(in_beat_t'{ALL_ONES, 31'd0, ALL_ONES}, 1'b1);
        offer_beat(in_beat_t'{31'd0, 31'd0, 31'd13}, 1'b1);
        offer_beat(in_beat_t'{31'd12345, 31'd1, 31'd1}, 1'b1);
        offer_beat(in_beat_t'{ALL_ONES, ALL_ONES, 31'd1}, 1'b1);
        offer_beat(in_beat_t'{31'd0, 31'd9, 31'd97}, 1'b1);
        offer_beat(in_beat_t'{ALL_ONES, ALL_ONES, ALL_ONES}, 1'b1);
        offer_beat(in_beat_t'{ALL_ONES - 31'd1, 31'd2, ALL_ONES}, 1'b1);
        offer_beat(in_beat_t'{ALL_ONES - 31'd1, ALL_ONES, ALL_ONES}, 1'b1);
        offer_beat(in_beat_t'{31'd2, 31'd30, ALL_ONES}, 1'b1);
        offer_beat(in_beat_t'{31'd3, 31'h4000_0000, 31'd1000003}, 1'b1);
        offer_beat(in_beat_t'{31'd1000, 31'd17, 31'd7}, 1'b1);
        offer_beat(in_beat_t'{31'd123456789, 31'd987654321, 31'd2}, 1'b1);
        offer_beat(in_beat_t'{31'd2, 31'd10, 31'd1025}, 1'b1);
        offer_beat(in_beat_t'{31'h2AAA_AAAA, 31'h5555_5555, 31'h7FFF_FFFE}, 1'b1);
        offer_beat(in_beat_t'{31'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555}, 1'b1);
        offer_beat(in_beat_t'{31'd1, ALL_ONES, 31'd65537}, 1'b1);
        offer_beat(in_beat_t'{31'd4, 31'd1, 31'd5}, 1'b1);

        wait_for_drain();

        // mostly short exponents to keep the run short, some full width
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == RANDOM_BEATS / 2) wait_for_drain();

            beat.base_value = OPERAND_WIDTH'($urandom);
            if ($urandom_range(99) < 10)
                beat.base_value = OPERAND_WIDTH'($urandom_range(0, 15));

            pick = $urandom_range(99);
            if (pick < 4)
                beat.modulus = '0;
            else if (pick < 8)
                beat.modulus = OPERAND_WIDTH'(1);
            else if (pick < 25)
                beat.modulus = OPERAND_WIDTH'($urandom_range(2, 1000));
            else
                beat.modulus = OPERAND_WIDTH'($urandom);

            if ($urandom_range(99) < 12) begin
                beat.exponent = OPERAND_WIDTH'($urandom);
            end else begin
                exp_bits      = $urandom_range(0, 10);
                beat.exponent = OPERAND_WIDTH'($urandom) & ~(ALL_ONES << exp_bits);
            end

            offer_beat(beat, !(n >= 200 && n < 260));
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
